// ===== hw/rtl/e2r_pkg.sv =====
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared constants, types and rounding helpers for the Euler rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

   localparam int TRIG_FRAC_BITS = 14;
   localparam int ANGLE_W        = 16;
   localparam int ELEM_W         = 16;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int PROD_W         = 2 * TRIG_W;
   localparam int SUM_W          = PROD_W + 1;

   // angle units: 1/64 degree
   localparam int HALF_TURN_DEG  = 180;
   localparam int UNITS_PER_DEG  = 64;
   localparam int HALF_UNITS     = HALF_TURN_DEG * UNITS_PER_DEG;
   localparam int FULL_UNITS     = 2 * HALF_UNITS;
   localparam int QUARTER_UNITS  = FULL_UNITS / 4;
   localparam int EIGHTH_UNITS   = FULL_UNITS / 8;
   localparam int RED_W          = 15;
   localparam int OCT_W          = 12;

   // pi in Q2.62, cut to 50 fractional bits, split over the half-turn divisor
   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;
   localparam logic [63:0] PI_Q50 = PI_Q62 >> 12;
   localparam logic [63:0] PI_QUO = PI_Q50 / HALF_UNITS;
   localparam logic [63:0] PI_REM = PI_Q50 % HALF_UNITS;
   localparam int          QUO_W  = 40;
   localparam int          REM_W  = 14;
   localparam int          HI_W   = QUO_W + OCT_W;
   localparam int          LO_W   = REM_W + OCT_W;

   // remainder divide: 11520 = 256 * 45, exact reciprocal for 18-bit values
   localparam int          DIV_PRE_SHIFT = 8;
   localparam int          DIV_ODD       = HALF_UNITS / 256;
   localparam int          DIV_N         = LO_W - DIV_PRE_SHIFT;
   localparam int          DIV_L         = 6;
   localparam logic [63:0] DIV_M         =
      ((64'd1 << (DIV_N + DIV_L)) + DIV_ODD - 1) / DIV_ODD;
   localparam int          DIV_M_W       = DIV_N + 1;

   localparam int SERIES_TERMS = 7;
   localparam int SC_LAT       = 6 + 3 * SERIES_TERMS + 1;
   localparam int VLD_LEN      = SC_LAT + 4;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = 2;

   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) << (TRIG_FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] ONE_POS  = SUM_W'(1) << TRIG_FRAC_BITS;
   localparam logic signed [SUM_W-1:0] ONE_NEG  = -ONE_POS;

   typedef struct packed {
      logic [RED_W-1:0] ax;
      logic [RED_W-1:0] ay;
      logic [RED_W-1:0] az;
   } angle_set_type;

   // round half up (towards +inf) to TRIG_FRAC_BITS fractional bits
   function automatic logic signed [SUM_W-1:0] frac_round(
      input logic signed [SUM_W-1:0] v);
      frac_round = (v + HALF_LSB) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic logic [ELEM_W-1:0] sat_unit(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      c = v;
      if (v > ONE_POS) begin
         c = ONE_POS;
      end else if (v < ONE_NEG) begin
         c = ONE_NEG;
      end
      sat_unit = c[ELEM_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/euler_to_rotation_matrix.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// 3x3 rotation matrix from three Euler angles, Q1.14 elements.
// ----------------------------------------------------------------------------
// Takes one transaction per clock when nothing stalls: three angles (degrees,
// 6 fractional bits, any 16-bit pattern) and returns the nine matrix elements
// in Q1.14, saturated to +/-1.0. Throughput is one transaction per cycle when
// nothing stalls. The sine/cosine pipeline has 6 stages of octant fold and
// radian scaling, three stages for each of the seven Taylor terms (one
// 32x32 multiply, one reciprocal multiply for the factorial divide, one
// accumulate) and a quadrant-restore stage; four matrix stages and a result
// register follow. The input register feeds a four-entry FIFO, so req_stall
// only rises once the FIFO has filled behind a stalled result; the pipeline
// itself freezes as a whole while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_rotation_matrix import e2r_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [ANGLE_W-1:0] req_angle_x,
   input  wire logic signed [ANGLE_W-1:0] req_angle_y,
   input  wire logic signed [ANGLE_W-1:0] req_angle_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [ELEM_W-1:0]       rsp_elem_r0c0,
   output logic signed [ELEM_W-1:0]       rsp_elem_r0c1,
   output logic signed [ELEM_W-1:0]       rsp_elem_r0c2,
   output logic signed [ELEM_W-1:0]       rsp_elem_r1c0,
   output logic signed [ELEM_W-1:0]       rsp_elem_r1c1,
   output logic signed [ELEM_W-1:0]       rsp_elem_r1c2,
   output logic signed [ELEM_W-1:0]       rsp_elem_r2c0,
   output logic signed [ELEM_W-1:0]       rsp_elem_r2c1,
   output logic signed [ELEM_W-1:0]       rsp_elem_r2c2
);

   // front to FIFO
   logic          push;
   logic          queue_full;
   angle_set_type push_item;
   // FIFO to back end
   logic          pop;
   logic          head_valid;
   angle_set_type head;

   // reduces each angle modulo a full turn and registers the transaction
   e2r_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_angle_x (req_angle_x),
      .req_angle_y (req_angle_y),
      .req_angle_z (req_angle_z),
      .queue_full  (queue_full),
      .push        (push),
      .push_item   (push_item)
   );

   // decouples the input side from stalls at the result side
   e2r_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // sine/cosine pipelines, matrix arithmetic and result register
   e2r_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_elem_r0c0 (rsp_elem_r0c0),
      .rsp_elem_r0c1 (rsp_elem_r0c1),
      .rsp_elem_r0c2 (rsp_elem_r0c2),
      .rsp_elem_r1c0 (rsp_elem_r1c0),
      .rsp_elem_r1c1 (rsp_elem_r1c1),
      .rsp_elem_r1c2 (rsp_elem_r1c2),
      .rsp_elem_r2c0 (rsp_elem_r2c0),
      .rsp_elem_r2c1 (rsp_elem_r2c1),
      .rsp_elem_r2c2 (rsp_elem_r2c2)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/e2r_front.sv =====
// ----------------------------------------------------------------------------
// e2r_front
// Input register: takes angle triples and reduces each modulo a full turn.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_front import e2r_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic signed [ANGLE_W-1:0] req_angle_x,
   input  wire logic signed [ANGLE_W-1:0] req_angle_y,
   input  wire logic signed [ANGLE_W-1:0] req_angle_z,
   input  wire logic                      queue_full,
   output logic                           push,
   output angle_set_type                  push_item
);

   logic          valid_ff, valid_in;
   angle_set_type item_ff, item_in;

   function automatic logic [RED_W-1:0] reduce(input logic signed [ANGLE_W-1:0] v);
      logic signed [ANGLE_W+1:0] vv;
      logic signed [ANGLE_W+1:0] r;
      vv = (ANGLE_W+2)'(v);
      if (vv < -(ANGLE_W+2)'(FULL_UNITS)) begin
         r = vv + (ANGLE_W+2)'(2 * FULL_UNITS);
      end else if (vv < 0) begin
         r = vv + (ANGLE_W+2)'(FULL_UNITS);
      end else if (vv >= (ANGLE_W+2)'(FULL_UNITS)) begin
         r = vv - (ANGLE_W+2)'(FULL_UNITS);
      end else begin
         r = vv;
      end
      reduce = r[RED_W-1:0];
   endfunction

   assign req_stall = valid_ff & queue_full;
   assign push      = valid_ff & ~queue_full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (!req_stall) begin
         valid_in   = req_valid;
         item_in.ax = reduce(req_angle_x);
         item_in.ay = reduce(req_angle_y);
         item_in.az = reduce(req_angle_z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/e2r_queue.sv =====
// ----------------------------------------------------------------------------
// e2r_queue
// Short FIFO between the input side and the trig/matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_queue import e2r_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  angle_set_type push_item,
   output logic         full,
   input  wire logic    pop,
   output angle_set_type head,
   output logic         head_valid
);

   angle_set_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

endmodule

`default_nettype wire

// ===== hw/rtl/e2r_sincos.sv =====
// ----------------------------------------------------------------------------
// e2r_sincos
// Pipelined sine/cosine of one reduced angle: octant fold, radian scale,
// seven-term Taylor series in Q1.31, quadrant restore.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_sincos import e2r_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     adv,
   input  wire logic [RED_W-1:0]         angle,
   output logic signed [TRIG_W-1:0]      sin_out,
   output logic signed [TRIG_W-1:0]      cos_out
);

   localparam logic [31:0] Q31_ONE = 32'h8000_0000;
   localparam logic [33:0] FRAC_HALF = 34'd1 << (30 - TRIG_FRAC_BITS);

   // fold
   logic [1:0]       q_c;
   logic [RED_W-1:0] rem_c;
   logic             sw_c;
   logic [OCT_W-1:0] t_c;
   logic [1:0]       q0_ff, q1_ff, q2_ff, q3_ff, q4_ff;
   logic             sw0_ff, sw1_ff, sw2_ff, sw3_ff, sw4_ff;
   logic [OCT_W-1:0] t0_ff;
   // radian scale
   logic [HI_W-1:0]  hi1_ff, hi2_ff;
   logic [LO_W-1:0]  lo1_ff;
   logic [DIV_N+DIV_M_W-1:0] lod2_ff;
   logic [52:0]      r50_rnd;
   logic [31:0]      r3_ff, r4_ff;
   logic [63:0]      rr4_ff, rr_rnd;
   // series
   logic [31:0]        st_ff [0:SERIES_TERMS];
   logic [31:0]        ct_ff [0:SERIES_TERMS];
   logic [31:0]        r2_ff [0:SERIES_TERMS];
   logic signed [33:0] ss_ff [0:SERIES_TERMS];
   logic signed [33:0] cs_ff [0:SERIES_TERMS];
   logic [1:0]         q_ff  [0:SERIES_TERMS];
   logic               sw_ff [0:SERIES_TERMS];
   logic [63:0]        a_ps_ff [1:SERIES_TERMS];
   logic [63:0]        a_pc_ff [1:SERIES_TERMS];
   logic [31:0]        a_r2_ff [1:SERIES_TERMS];
   logic signed [33:0] a_ss_ff [1:SERIES_TERMS];
   logic signed [33:0] a_cs_ff [1:SERIES_TERMS];
   logic [1:0]         a_q_ff  [1:SERIES_TERMS];
   logic               a_sw_ff [1:SERIES_TERMS];
   logic [64:0]        b_ms_ff [1:SERIES_TERMS];
   logic [64:0]        b_mc_ff [1:SERIES_TERMS];
   logic [31:0]        b_r2_ff [1:SERIES_TERMS];
   logic signed [33:0] b_ss_ff [1:SERIES_TERMS];
   logic signed [33:0] b_cs_ff [1:SERIES_TERMS];
   logic [1:0]         b_q_ff  [1:SERIES_TERMS];
   logic               b_sw_ff [1:SERIES_TERMS];
   // output
   logic [33:0]              s_rnd, c_rnd;
   logic signed [TRIG_W-1:0] s_oct, c_oct, sb, cb, sin_in, cos_in;
   logic signed [TRIG_W-1:0] sin_ff, cos_ff;

   always_comb begin
      if (angle >= RED_W'(3 * QUARTER_UNITS)) begin
         q_c = 2'd3;
      end else if (angle >= RED_W'(2 * QUARTER_UNITS)) begin
         q_c = 2'd2;
      end else if (angle >= RED_W'(QUARTER_UNITS)) begin
         q_c = 2'd1;
      end else begin
         q_c = 2'd0;
      end
      unique case (q_c)
         2'd0:    rem_c = angle;
         2'd1:    rem_c = angle - RED_W'(QUARTER_UNITS);
         2'd2:    rem_c = angle - RED_W'(2 * QUARTER_UNITS);
         default: rem_c = angle - RED_W'(3 * QUARTER_UNITS);
      endcase
      sw_c = (rem_c > RED_W'(EIGHTH_UNITS));
      t_c  = sw_c ? OCT_W'(RED_W'(QUARTER_UNITS) - rem_c) : rem_c[OCT_W-1:0];
   end

   assign r50_rnd = 53'(hi2_ff) + 53'(lod2_ff[DIV_N+DIV_M_W-1:DIV_N+DIV_L])
                    + (53'd1 << 18);
   assign rr_rnd  = rr4_ff + (64'd1 << 30);

   always_ff @(posedge clock) begin
      if (adv) begin
         q0_ff   <= q_c;
         sw0_ff  <= sw_c;
         t0_ff   <= t_c;
         hi1_ff  <= t0_ff * PI_QUO[QUO_W-1:0];
         lo1_ff  <= t0_ff * PI_REM[REM_W-1:0];
         q1_ff   <= q0_ff;
         sw1_ff  <= sw0_ff;
         hi2_ff  <= hi1_ff;
         lod2_ff <= lo1_ff[LO_W-1:DIV_PRE_SHIFT] * DIV_M[DIV_M_W-1:0];
         q2_ff   <= q1_ff;
         sw2_ff  <= sw1_ff;
         r3_ff   <= r50_rnd[50:19];
         q3_ff   <= q2_ff;
         sw3_ff  <= sw2_ff;
         rr4_ff  <= r3_ff * r3_ff;
         r4_ff   <= r3_ff;
         q4_ff   <= q3_ff;
         sw4_ff  <= sw3_ff;
         r2_ff[0] <= rr_rnd[62:31];
         st_ff[0] <= r4_ff;
         ct_ff[0] <= Q31_ONE;
         ss_ff[0] <= signed'({2'b00, r4_ff});
         cs_ff[0] <= signed'({2'b00, Q31_ONE});
         q_ff[0]  <= q4_ff;
         sw_ff[0] <= sw4_ff;
      end
   end

   for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
      localparam int unsigned DS = (2 * k) * (2 * k + 1);
      localparam int unsigned DC = (2 * k - 1) * (2 * k);
      localparam int unsigned LS = $clog2(DS);
      localparam int unsigned LC = $clog2(DC);
      localparam logic [63:0] MS = ((64'd1 << (32 + LS)) + DS - 1) / DS;
      localparam logic [63:0] MC = ((64'd1 << (32 + LC)) + DC - 1) / DC;

      logic [64:0] ms_sh, mc_sh;
      logic [31:0] st_new, ct_new;

      assign ms_sh  = b_ms_ff[k] >> (32 + LS);
      assign mc_sh  = b_mc_ff[k] >> (32 + LC);
      assign st_new = ms_sh[31:0];
      assign ct_new = mc_sh[31:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            a_ps_ff[k] <= st_ff[k-1] * r2_ff[k-1];
            a_pc_ff[k] <= ct_ff[k-1] * r2_ff[k-1];
            a_r2_ff[k] <= r2_ff[k-1];
            a_ss_ff[k] <= ss_ff[k-1];
            a_cs_ff[k] <= cs_ff[k-1];
            a_q_ff[k]  <= q_ff[k-1];
            a_sw_ff[k] <= sw_ff[k-1];

            b_ms_ff[k] <= a_ps_ff[k][62:31] * MS[32:0];
            b_mc_ff[k] <= a_pc_ff[k][62:31] * MC[32:0];
            b_r2_ff[k] <= a_r2_ff[k];
            b_ss_ff[k] <= a_ss_ff[k];
            b_cs_ff[k] <= a_cs_ff[k];
            b_q_ff[k]  <= a_q_ff[k];
            b_sw_ff[k] <= a_sw_ff[k];

            st_ff[k] <= st_new;
            ct_ff[k] <= ct_new;
            r2_ff[k] <= b_r2_ff[k];
            q_ff[k]  <= b_q_ff[k];
            sw_ff[k] <= b_sw_ff[k];
            if ((k % 2) == 1) begin
               ss_ff[k] <= b_ss_ff[k] - signed'({2'b00, st_new});
               cs_ff[k] <= b_cs_ff[k] - signed'({2'b00, ct_new});
            end else begin
               ss_ff[k] <= b_ss_ff[k] + signed'({2'b00, st_new});
               cs_ff[k] <= b_cs_ff[k] + signed'({2'b00, ct_new});
            end
         end
      end
   end

   always_comb begin
      s_rnd = ss_ff[SERIES_TERMS] + FRAC_HALF;
      c_rnd = cs_ff[SERIES_TERMS] + FRAC_HALF;
      s_oct = signed'({1'b0, s_rnd[31:31-TRIG_FRAC_BITS]});
      c_oct = signed'({1'b0, c_rnd[31:31-TRIG_FRAC_BITS]});
      sb    = sw_ff[SERIES_TERMS] ? c_oct : s_oct;
      cb    = sw_ff[SERIES_TERMS] ? s_oct : c_oct;
      unique case (q_ff[SERIES_TERMS])
         2'd0: begin sin_in = sb;  cos_in = cb;  end
         2'd1: begin sin_in = cb;  cos_in = -sb; end
         2'd2: begin sin_in = -sb; cos_in = -cb; end
         default: begin sin_in = -cb; cos_in = sb; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/e2r_back.sv =====
// ----------------------------------------------------------------------------
// e2r_back
// Trig units for the three angles, matrix products and sums, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_back import e2r_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  angle_set_type      head,
   input  wire logic          head_valid,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [ELEM_W-1:0]  rsp_elem_r0c0,
   output logic [ELEM_W-1:0]  rsp_elem_r0c1,
   output logic [ELEM_W-1:0]  rsp_elem_r0c2,
   output logic [ELEM_W-1:0]  rsp_elem_r1c0,
   output logic [ELEM_W-1:0]  rsp_elem_r1c1,
   output logic [ELEM_W-1:0]  rsp_elem_r1c2,
   output logic [ELEM_W-1:0]  rsp_elem_r2c0,
   output logic [ELEM_W-1:0]  rsp_elem_r2c1,
   output logic [ELEM_W-1:0]  rsp_elem_r2c2
);

   logic               adv;
   logic [VLD_LEN-1:0] vld_ff;
   logic               rsp_valid_ff;

   logic signed [TRIG_W-1:0] sx, cx, sy, cy, sz, cz;

   // M1
   logic signed [PROD_W-1:0] p_sxsy_ff, p_czsy_ff, p_sysz_ff;
   logic signed [PROD_W-1:0] p_cycz_ff, p_cxsz_ff, p_sxsz_ff, p_cysz_ff;
   logic signed [PROD_W-1:0] p_cxcz_ff, p_czsx_ff, p_cysx_ff, p_cxcy_ff;
   logic signed [TRIG_W-1:0] sx1_ff, cx1_ff, cz1_ff, sy1_ff;
   // M2
   logic signed [SUM_W-1:0]  rnd_sxsy, rnd_czsy, rnd_sysz;
   logic signed [TRIG_W-1:0] r_sxsy_ff, r_czsy_ff, r_sysz_ff;
   logic signed [PROD_W-1:0] q_cycz_ff, q_cxsz_ff, q_sxsz_ff, q_cysz_ff;
   logic signed [PROD_W-1:0] q_cxcz_ff, q_czsx_ff, q_cysx_ff, q_cxcy_ff;
   logic signed [TRIG_W-1:0] sx2_ff, cx2_ff, cz2_ff, sy2_ff;
   // M3
   logic signed [PROD_W-1:0] t_czsxsy_ff, t_cxczsy_ff, t_sxsysz_ff, t_cxsysz_ff;
   logic signed [PROD_W-1:0] u_cycz_ff, u_cxsz_ff, u_sxsz_ff, u_cysz_ff;
   logic signed [PROD_W-1:0] u_cxcz_ff, u_czsx_ff, u_cysx_ff, u_cxcy_ff;
   logic signed [TRIG_W-1:0] sy3_ff;
   // M4
   logic signed [SUM_W-1:0]  e0_ff, e1_ff, e2_ff, e3_ff, e4_ff, e5_ff;
   logic signed [SUM_W-1:0]  e6_ff, e7_ff, e8_ff;
   // result
   logic [ELEM_W-1:0] o0_ff, o1_ff, o2_ff, o3_ff, o4_ff, o5_ff, o6_ff, o7_ff, o8_ff;

   assign adv = ~rsp_valid_ff | ~rsp_stall;
   assign pop = adv & head_valid;

   e2r_sincos u_trig_x (.clock(clock), .adv(adv), .angle(head.ax),
                        .sin_out(sx), .cos_out(cx));
   e2r_sincos u_trig_y (.clock(clock), .adv(adv), .angle(head.ay),
                        .sin_out(sy), .cos_out(cy));
   e2r_sincos u_trig_z (.clock(clock), .adv(adv), .angle(head.az),
                        .sin_out(sz), .cos_out(cz));

   assign rnd_sxsy = frac_round(SUM_W'(p_sxsy_ff));
   assign rnd_czsy = frac_round(SUM_W'(p_czsy_ff));
   assign rnd_sysz = frac_round(SUM_W'(p_sysz_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLD_LEN-2:0], head_valid};
         rsp_valid_ff <= vld_ff[VLD_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_sxsy_ff <= sx * sy;
         p_czsy_ff <= cz * sy;
         p_sysz_ff <= sy * sz;
         p_cycz_ff <= cy * cz;
         p_cxsz_ff <= cx * sz;
         p_sxsz_ff <= sx * sz;
         p_cysz_ff <= cy * sz;
         p_cxcz_ff <= cx * cz;
         p_czsx_ff <= cz * sx;
         p_cysx_ff <= cy * sx;
         p_cxcy_ff <= cx * cy;
         sx1_ff <= sx;
         cx1_ff <= cx;
         cz1_ff <= cz;
         sy1_ff <= sy;

         r_sxsy_ff <= rnd_sxsy[TRIG_W-1:0];
         r_czsy_ff <= rnd_czsy[TRIG_W-1:0];
         r_sysz_ff <= rnd_sysz[TRIG_W-1:0];
         q_cycz_ff <= p_cycz_ff;
         q_cxsz_ff <= p_cxsz_ff;
         q_sxsz_ff <= p_sxsz_ff;
         q_cysz_ff <= p_cysz_ff;
         q_cxcz_ff <= p_cxcz_ff;
         q_czsx_ff <= p_czsx_ff;
         q_cysx_ff <= p_cysx_ff;
         q_cxcy_ff <= p_cxcy_ff;
         sx2_ff <= sx1_ff;
         cx2_ff <= cx1_ff;
         cz2_ff <= cz1_ff;
         sy2_ff <= sy1_ff;

         t_czsxsy_ff <= cz2_ff * r_sxsy_ff;
         t_cxczsy_ff <= cx2_ff * r_czsy_ff;
         t_sxsysz_ff <= sx2_ff * r_sysz_ff;
         t_cxsysz_ff <= cx2_ff * r_sysz_ff;
         u_cycz_ff <= q_cycz_ff;
         u_cxsz_ff <= q_cxsz_ff;
         u_sxsz_ff <= q_sxsz_ff;
         u_cysz_ff <= q_cysz_ff;
         u_cxcz_ff <= q_cxcz_ff;
         u_czsx_ff <= q_czsx_ff;
         u_cysx_ff <= q_cysx_ff;
         u_cxcy_ff <= q_cxcy_ff;
         sy3_ff    <= sy2_ff;

         e0_ff <= SUM_W'(u_cycz_ff);
         e1_ff <= SUM_W'(t_czsxsy_ff) - SUM_W'(u_cxsz_ff);
         e2_ff <= SUM_W'(t_cxczsy_ff) + SUM_W'(u_sxsz_ff);
         e3_ff <= SUM_W'(u_cysz_ff);
         e4_ff <= SUM_W'(u_cxcz_ff) + SUM_W'(t_sxsysz_ff);
         e5_ff <= SUM_W'(t_cxsysz_ff) - SUM_W'(u_czsx_ff);
         e6_ff <= -SUM_W'(sy3_ff);
         e7_ff <= SUM_W'(u_cysx_ff);
         e8_ff <= SUM_W'(u_cxcy_ff);

         o0_ff <= sat_unit(frac_round(e0_ff));
         o1_ff <= sat_unit(frac_round(e1_ff));
         o2_ff <= sat_unit(frac_round(e2_ff));
         o3_ff <= sat_unit(frac_round(e3_ff));
         o4_ff <= sat_unit(frac_round(e4_ff));
         o5_ff <= sat_unit(frac_round(e5_ff));
         o6_ff <= sat_unit(e6_ff);
         o7_ff <= sat_unit(frac_round(e7_ff));
         o8_ff <= sat_unit(frac_round(e8_ff));
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elem_r0c0 = o0_ff;
   assign rsp_elem_r0c1 = o1_ff;
   assign rsp_elem_r0c2 = o2_ff;
   assign rsp_elem_r1c0 = o3_ff;
   assign rsp_elem_r1c1 = o4_ff;
   assign rsp_elem_r1c2 = o5_ff;
   assign rsp_elem_r2c0 = o6_ff;
   assign rsp_elem_r2c1 = o7_ff;
   assign rsp_elem_r2c2 = o8_ff;

   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while result held");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(vld_ff[VLD_LEN-1]))
      else $error("result valid without a transaction in the last stage");

   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (signed'(o0_ff) <= 16'sd16384 && signed'(o0_ff) >= -16'sd16384))
      else $error("matrix element beyond unit range");

endmodule

`default_nettype wire

// ===== tb/sv/euler_to_rotation_matrix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_tb
// Self-checking bench for the Euler angle to rotation matrix block.
// ----------------------------------------------------------------------------
// A directed table of angle triples (zero, quarter turns, octant edges, field
// extremes) goes first, then random triples, each scored against its typed-in
// matrix or an in-bench fixed-point model of the sine/cosine series and matrix
// arithmetic. Both channels idle and stall at random across several phases.
// ----------------------------------------------------------------------------

module euler_to_rotation_matrix_tb import e2r_pkg::*;;

   localparam int N_RANDOM = 1400;

   typedef struct packed {
      logic signed [ELEM_W-1:0] e0, e1, e2, e3, e4, e5, e6, e7, e8;
   } matrix_type;

   typedef struct {
      logic signed [ANGLE_W-1:0] ax, ay, az;
      bit                        known;  // expected matrix typed in below
      matrix_type                m;
   } angle_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ANGLE_W-1:0] req_angle_x = '0, req_angle_y = '0, req_angle_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ELEM_W-1:0] rsp_elem_r0c0, rsp_elem_r0c1, rsp_elem_r0c2;
   logic signed [ELEM_W-1:0] rsp_elem_r1c0, rsp_elem_r1c1, rsp_elem_r1c2;
   logic signed [ELEM_W-1:0] rsp_elem_r2c0, rsp_elem_r2c1, rsp_elem_r2c2;

   matrix_type matrix_q[$];
   int         errors = 0;
   int         send_idle_pct = 0;
   int         stall_pct = 0;

   euler_to_rotation_matrix u_dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_angle_x, .req_angle_y, .req_angle_z,
      .rsp_valid, .rsp_stall,
      .rsp_elem_r0c0, .rsp_elem_r0c1, .rsp_elem_r0c2,
      .rsp_elem_r1c0, .rsp_elem_r1c1, .rsp_elem_r1c2,
      .rsp_elem_r2c0, .rsp_elem_r2c1, .rsp_elem_r2c2
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model
   function automatic longint rnd_shift(longint v);
      return (v + (64'sd1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic longint clamp_unit(longint v);
      longint one;
      one = 64'sd1 << TRIG_FRAC_BITS;
      if (v > one) return one;
      if (v < -one) return -one;
      return v;
   endfunction

   function automatic longint q31_to_frac(longint unsigned q);
      return longint'((q + (64'd1 << (30 - TRIG_FRAC_BITS))) >> (31 - TRIG_FRAC_BITS));
   endfunction

   // Taylor series on one octant, t in [0, EIGHTH_UNITS]
   function automatic void octant_trig(input longint unsigned t, output longint s,
                                       output longint c);
      longint unsigned r50, r, r2, st, ss, ct, cs;
      r50 = t * (PI_Q62 >> 12) / 64'(HALF_UNITS);
      r   = (r50 + (64'd1 << 18)) >> 19;
      r2  = (r * r + (64'd1 << 30)) >> 31;
      st = r; ss = r; ct = 64'd1 << 31; cs = ct;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         st = ((st * r2) >> 31) / 64'((2 * k) * (2 * k + 1));
         ct = ((ct * r2) >> 31) / 64'((2 * k - 1) * (2 * k));
         if (k % 2) begin
            ss -= st; cs -= ct;
         end else begin
            ss += st; cs += ct;
         end
      end
      s = q31_to_frac(ss);
      c = q31_to_frac(cs);
   endfunction

   function automatic void angle_trig(input logic signed [ANGLE_W-1:0] ang,
                                      output longint s, output longint c);
      longint a, rem, sb, cb, tmp;
      int q;
      a = longint'(ang) % FULL_UNITS;
      if (a < 0) a += FULL_UNITS;
      q   = int'(a / QUARTER_UNITS);
      rem = a % QUARTER_UNITS;
      if (rem > EIGHTH_UNITS) octant_trig(QUARTER_UNITS - rem, cb, sb);
      else                    octant_trig(rem, sb, cb);
      case (q)
         1: begin tmp = sb; sb = cb;  cb = -tmp; end
         2: begin sb = -sb; cb = -cb; end
         3: begin tmp = sb; sb = -cb; cb = tmp;  end
         default: ;
      endcase
      s = sb;
      c = cb;
   endfunction

   function automatic logic signed [ELEM_W-1:0] fin(longint w);
      return ELEM_W'(clamp_unit(rnd_shift(w)));
   endfunction

   function automatic matrix_type rotation_of(logic signed [ANGLE_W-1:0] ax, ay, az);
      longint sx, cx, sy, cy, sz, cz, sxsy, czsy, sysz;
      matrix_type m;
      angle_trig(ax, sx, cx);
      angle_trig(ay, sy, cy);
      angle_trig(az, sz, cz);
      sxsy = rnd_shift(sx * sy);
      czsy = rnd_shift(cz * sy);
      sysz = rnd_shift(sy * sz);
      m.e0 = fin(cy * cz);
      m.e1 = fin(cz * sxsy - cx * sz);
      m.e2 = fin(cx * czsy + sx * sz);
      m.e3 = fin(cy * sz);
      m.e4 = fin(cx * cz + sx * sysz);
      m.e5 = fin(cx * sysz - cz * sx);
      m.e6 = ELEM_W'(clamp_unit(-sy));
      m.e7 = fin(cy * sx);
      m.e8 = fin(cx * cy);
      return m;
   endfunction

   // --------------------------------------------------------------- stimulus
   localparam logic signed [ELEM_W-1:0] P1 = 16'sd16384;
   localparam logic signed [ELEM_W-1:0] M1 = -16'sd16384;
   localparam logic signed [ELEM_W-1:0] Z0 = 16'sd0;
   localparam logic signed [ANGLE_W-1:0] D90  = 16'sd5760;
   localparam logic signed [ANGLE_W-1:0] D180 = 16'sd11520;
   localparam logic signed [ANGLE_W-1:0] D45  = 16'sd2880;

   angle_row_type angle_table[] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
      '{16'sd0, 16'sd0, D90, 1'b1, '{Z0, M1, Z0, P1, Z0, Z0, Z0, Z0, P1}},
      '{16'sd0, D90, 16'sd0, 1'b1, '{Z0, Z0, P1, Z0, P1, Z0, M1, Z0, Z0}},
      '{D90, 16'sd0, 16'sd0, 1'b1, '{P1, Z0, Z0, Z0, Z0, M1, Z0, P1, Z0}},
      '{D180, D180, D180, 1'b1, '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
      '{-16'sd23040, 16'sd23040, 16'sd0, 1'b1, '{P1, Z0, Z0, Z0, P1, Z0, Z0, Z0, P1}},
      '{D45, D45, D45, 1'b0, '0},
      '{16'sd2879, 16'sd2881, 16'sd2880, 1'b0, '0},
      '{16'sd5759, 16'sd5761, 16'sd1, 1'b0, '0},
      '{-16'sd1, -16'sd5760, -16'sd11520, 1'b0, '0},
      '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0},
      '{16'sd17280, 16'sd8640, 16'sd14400, 1'b0, '0},
      '{16'sd20160, 16'sd23039, 16'sd11519, 1'b0, '0},
      '{16'sh5555, -16'sh5556, 16'sh2AAA, 1'b0, '0}
   };

   task automatic send_angles(logic signed [ANGLE_W-1:0] ax, ay, az, bit known,
                              matrix_type m);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_angle_x <= ax;
      req_angle_y <= ay;
      req_angle_z <= az;
      matrix_q.push_back(known ? m : rotation_of(ax, ay, az));
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      case ($urandom_range(3))
         0: return ANGLE_W'($urandom);
         1: return ANGLE_W'($urandom_range(FULL_UNITS - 1));
         2: return ANGLE_W'(QUARTER_UNITS * $urandom_range(7) + $urandom_range(6) - 3);
         default: return ANGLE_W'(EIGHTH_UNITS * $urandom_range(15) - 32768 * $urandom_range(1));
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (angle_table[i])
         send_angles(angle_table[i].ax, angle_table[i].ay, angle_table[i].az,
                     angle_table[i].known, angle_table[i].m);
      // idling phases: none, sender, receiver, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct <= (ph == 1) ? 46 : (ph == 3) ? 20 : 0;
         stall_pct     <= (ph == 2) ? 46 : (ph == 3) ? 20 : 0;
         for (int n = 0; n < N_RANDOM / 4; n++)
            send_angles(random_angle(), random_angle(), random_angle(), 1'b0, '0);
      end
      req_valid <= 1'b0;
      while (matrix_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else             $display("Verification failed");
      $finish;
   end

   // receiver: random stall, then score accepted transactions
   always @(posedge clock) begin
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      matrix_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_elem_r0c0, rsp_elem_r0c1, rsp_elem_r0c2,
                 rsp_elem_r1c0, rsp_elem_r1c1, rsp_elem_r1c2,
                 rsp_elem_r2c0, rsp_elem_r2c1, rsp_elem_r2c2};
         if (matrix_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual %h", $realtime, got);
            errors++;
         end else begin
            want = matrix_q.pop_front();
            for (int k = 0; k < 9; k++)
               if (got[16*(8-k) +: 16] !== want[16*(8-k) +: 16]) begin
                  $display("%0t: element %0d expected %0d actual %0d", $realtime, k,
                           $signed(want[16*(8-k) +: 16]), $signed(got[16*(8-k) +: 16]));
                  errors++;
               end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule
